>>> hdl/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and codes for the linear queue with search.
// ----------------------------------------------------------------------------
package lfs_pkg;

    // Default queue depth and the cap on results of one search or show
    localparam int DEPTH_DEFAULT = 16;
    localparam int RESULT_CAP    = 16;
    localparam int CNT_W         = $clog2(RESULT_CAP + 1);

    typedef logic [2:0]         action_t;
    typedef logic [1:0]         status_t;
    typedef logic [3:0]         position_t;
    typedef logic signed [31:0] value_t;

    // Action codes
    localparam action_t ACT_ENQUEUE = 3'd0;
    localparam action_t ACT_DEQUEUE = 3'd1;
    localparam action_t ACT_SEARCH  = 3'd2;
    localparam action_t ACT_SHOW    = 3'd3;
    localparam action_t ACT_RESET   = 3'd4;

    // Status codes
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_FULL     = 2'd2;
    localparam status_t ST_NOTFOUND = 2'd3;

    typedef struct packed {
        action_t action;
        value_t  data_value;
    } request_t;

    typedef struct packed {
        status_t   status;
        position_t position;
        value_t    item_value;
        logic      last;
    } result_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SCAN,
        S_FLUSH
    } state_t;

    // Result the controller asks the datapath to emit
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_ENQ_OK,
        EMIT_ENQ_FULL,
        EMIT_EMPTY,
        EMIT_DEQ,
        EMIT_RESET,
        EMIT_FLUSH
    } emit_t;

    // Controller to datapath commands
    typedef struct packed {
        logic  load;
        logic  push;
        logic  pop;
        logic  clear;
        logic  scan_start;
        logic  scan_step;
        logic  rd_head;
        emit_t emit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic scan_more;
    } stat_t;

endpackage

>>> hdl/lfs_ctrl.sv
// ----------------------------------------------------------------------------
// lfs_ctrl
// Sequencer: decodes each accepted word and steps the datapath through
// enqueue, dequeue, reset, scan and flush.
// ----------------------------------------------------------------------------
module lfs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lfs_pkg::action_t    action,
    input  lfs_pkg::stat_t      stat,
    output logic                busy,
    output lfs_pkg::cmd_t       cmd
);

    lfs_pkg::state_t state_reg;
    lfs_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != lfs_pkg::S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = lfs_pkg::EMIT_NONE;
        case (state_reg)
            lfs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (action)
                        lfs_pkg::ACT_ENQUEUE:
                        begin
                            if (stat.full)
                            begin
                                cmd.emit = lfs_pkg::EMIT_ENQ_FULL;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                                cmd.emit = lfs_pkg::EMIT_ENQ_OK;
                            end
                        end
                        lfs_pkg::ACT_DEQUEUE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit = lfs_pkg::EMIT_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_head = 1'b1;
                                state_next  = lfs_pkg::S_DEQ;
                            end
                        end
                        lfs_pkg::ACT_SEARCH, lfs_pkg::ACT_SHOW:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit = lfs_pkg::EMIT_EMPTY;
                            end
                            else
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = lfs_pkg::S_SCAN;
                            end
                        end
                        lfs_pkg::ACT_RESET:
                        begin
                            cmd.clear = 1'b1;
                            cmd.emit  = lfs_pkg::EMIT_RESET;
                        end
                        default:
                        begin
                            // unused codes: drop the word
                        end
                    endcase
                end
            end
            lfs_pkg::S_DEQ:
            begin
                cmd.emit   = lfs_pkg::EMIT_DEQ;
                cmd.pop    = 1'b1;
                state_next = lfs_pkg::S_IDLE;
            end
            lfs_pkg::S_SCAN:
            begin
                if (stat.scan_more)
                begin
                    cmd.scan_step = 1'b1;
                end
                else
                begin
                    state_next = lfs_pkg::S_FLUSH;
                end
            end
            lfs_pkg::S_FLUSH:
            begin
                cmd.emit   = lfs_pkg::EMIT_FLUSH;
                state_next = lfs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lfs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/lfs_datapath.sv
// ----------------------------------------------------------------------------
// lfs_datapath
// Slot memory, head and tail pointers, scan pipeline with one pending match,
// and the registered result word.
// ----------------------------------------------------------------------------
module lfs_datapath
#(
    parameter int DEPTH = lfs_pkg::DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lfs_pkg::request_t   request,
    input  lfs_pkg::cmd_t       cmd,
    output lfs_pkg::stat_t      stat,
    output logic                result_valid,
    output lfs_pkg::result_t    result
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = AW + 1;

    lfs_pkg::value_t mem [DEPTH];

    logic [IW-1:0]             head_reg;
    logic [IW-1:0]             head_next;
    logic [IW-1:0]             tail_reg;
    logic [IW-1:0]             tail_next;
    logic [IW-1:0]             scan_idx_reg;
    logic [IW-1:0]             scan_idx_next;
    logic [AW-1:0]             rd_addr;
    lfs_pkg::value_t           rd_data_reg;
    logic                      rd_valid_reg;
    logic [IW-1:0]             rd_idx_reg;
    lfs_pkg::value_t           key_reg;
    logic                      show_reg;
    logic [lfs_pkg::CNT_W-1:0] found_cnt_reg;
    logic [lfs_pkg::CNT_W-1:0] found_cnt_next;
    logic                      pend_valid_reg;
    logic                      pend_valid_next;
    lfs_pkg::position_t        pend_pos_reg;
    lfs_pkg::value_t           pend_value_reg;
    logic                      below_cap;
    logic                      hit;
    logic                      result_valid_reg;
    logic                      result_valid_next;
    lfs_pkg::result_t          result_reg;
    lfs_pkg::result_t          result_next;

    // Status toward the controller
    assign below_cap      = (found_cnt_reg < lfs_pkg::CNT_W'(lfs_pkg::RESULT_CAP));
    assign stat.empty     = (head_reg >= tail_reg);
    assign stat.full      = (tail_reg == IW'(DEPTH));
    assign stat.scan_more = (scan_idx_reg < tail_reg) && below_cap;

    // Read address: head for dequeue, scan index otherwise
    assign rd_addr = cmd.rd_head ? head_reg[AW-1:0] : scan_idx_reg[AW-1:0];

    // Slot memory: write at tail, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_reg[AW-1:0]] <= request.data_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // A scan read hits when it matches the key, or always for show
    assign hit = rd_valid_reg && below_cap && (show_reg || (rd_data_reg == key_reg));

    // Pointer and scan next values
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        scan_idx_next   = scan_idx_reg;
        found_cnt_next  = found_cnt_reg;
        pend_valid_next = pend_valid_reg;
        if (cmd.push)
        begin
            tail_next = tail_reg + IW'(1);
        end
        if (cmd.pop)
        begin
            head_next = head_reg + IW'(1);
        end
        if (cmd.clear)
        begin
            head_next = '0;
            tail_next = '0;
        end
        if (cmd.scan_start)
        begin
            scan_idx_next   = head_reg;
            found_cnt_next  = '0;
            pend_valid_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg + IW'(1);
        end
        if (hit)
        begin
            found_cnt_next  = found_cnt_reg + lfs_pkg::CNT_W'(1);
            pend_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            tail_reg         <= '0;
            scan_idx_reg     <= '0;
            found_cnt_reg    <= '0;
            pend_valid_reg   <= 1'b0;
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            scan_idx_reg     <= scan_idx_next;
            found_cnt_reg    <= found_cnt_next;
            pend_valid_reg   <= pend_valid_next;
            rd_valid_reg     <= cmd.scan_step;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers: key, mode, read index, pending match, result word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= request.data_value;
            show_reg <= (request.action == lfs_pkg::ACT_SHOW);
        end
        rd_idx_reg <= scan_idx_reg;
        if (hit)
        begin
            pend_pos_reg   <= lfs_pkg::position_t'(rd_idx_reg);
            pend_value_reg <= rd_data_reg;
        end
        result_reg <= result_next;
    end

    // Build the next result word
    always_comb
    begin
        result_valid_next      = 1'b1;
        result_next.status     = lfs_pkg::ST_OK;
        result_next.position   = '0;
        result_next.item_value = '0;
        result_next.last       = 1'b1;
        case (cmd.emit)
            lfs_pkg::EMIT_ENQ_OK:
            begin
                result_next.position   = lfs_pkg::position_t'(tail_reg);
                result_next.item_value = request.data_value;
            end
            lfs_pkg::EMIT_ENQ_FULL:
            begin
                result_next.status     = lfs_pkg::ST_FULL;
                result_next.item_value = request.data_value;
            end
            lfs_pkg::EMIT_EMPTY:
            begin
                result_next.status = lfs_pkg::ST_EMPTY;
            end
            lfs_pkg::EMIT_DEQ:
            begin
                result_next.position   = lfs_pkg::position_t'(head_reg);
                result_next.item_value = rd_data_reg;
            end
            lfs_pkg::EMIT_RESET:
            begin
                result_next.status = lfs_pkg::ST_OK;
            end
            lfs_pkg::EMIT_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    result_next.position   = pend_pos_reg;
                    result_next.item_value = pend_value_reg;
                end
                else
                begin
                    result_next.status     = lfs_pkg::ST_NOTFOUND;
                    result_next.item_value = key_reg;
                end
            end
            default:
            begin
                // a new match pushes out the previous pending one
                result_valid_next      = hit && pend_valid_reg;
                result_next.position   = pend_pos_reg;
                result_next.item_value = pend_value_reg;
                result_next.last       = 1'b0;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // scan reads never land in a cycle where the controller emits a result
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (cmd.emit == lfs_pkg::EMIT_NONE))
        else $error("scan read collides with a controller result");

    // head never passes tail
    assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("head passed tail");

    // tail stays within the array
    assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= IW'(DEPTH))
        else $error("tail beyond depth");

    // matches per scan never exceed the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        found_cnt_reg <= lfs_pkg::CNT_W'(lfs_pkg::RESULT_CAP))
        else $error("match count beyond cap");
`endif

endmodule

>>> hdl/linear_fifo_with_search.sv
// ----------------------------------------------------------------------------
// linear_fifo_with_search
// Non-circular array queue with enqueue, dequeue, search, show and reset.
//
//   channel   ports                          handshake
//   request   start, busy, request           taken when start & !busy
//   result    result_valid, result           single-cycle valid, no stall
//
// Enqueue and reset are handled in the accepting cycle; the result appears
// the next cycle and a new word may be taken in that same cycle. Unused
// actions are dropped with no result. Dequeue passes through S_DEQ for the
// registered memory read of the head. Search and show walk the live slots
// from head toward tail in S_SCAN, stopping early at the result cap, and end
// in S_FLUSH. The simple dual-port slot memory reads one slot per cycle.
// rst_n clears head and tail; slot contents are kept.
// The receiver cannot stall; each result word is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module linear_fifo_with_search
#(
    parameter int DEPTH = lfs_pkg::DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lfs_pkg::request_t request,
    output logic              result_valid,
    output lfs_pkg::result_t  result
);

    lfs_pkg::cmd_t  cmd;
    lfs_pkg::stat_t stat;

    // Sequencer
    lfs_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (request.action),
        .stat   (stat),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Storage and result path
    lfs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
